>>> rtl/dsh_pkg.sv
package dsh_pkg;

	// Point kinds within one square, in visiting order.
	localparam logic [2:0] PH_CENTER = 3'd0;
	localparam logic [2:0] PH_LEFT   = 3'd1;
	localparam logic [2:0] PH_TOP    = 3'd2;
	localparam logic [2:0] PH_RIGHT  = 3'd3;
	localparam logic [2:0] PH_BOTTOM = 3'd4;

	// Corners per generation and the last quadrant code.
	localparam logic [2:0] CORNER_COUNT = 3'd4;
	localparam logic [1:0] QUAD_LAST    = 2'd3;

	// Index of the last neighbour read per point.
	localparam logic [1:0] NB_LAST = 2'd3;

	typedef struct packed {
		logic       load_word;
		logic       acc_init;
		logic       clr_init;
		logic       clr_step;
		logic       rd_issue;
		logic [1:0] rd_sel;
		logic       div_start;
		logic       wr;
		logic       fin;
	} dsh_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic div_busy;
		logic out_full;
	} dsh_sts_t;

endpackage

>>> rtl/dsh_ram.sv
module dsh_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16641
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> rtl/dsh_div.sv
module dsh_div #(
	parameter int DVW = 31,
	parameter int DSW = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DVW-1:0] dividend,
	input  logic [DSW-1:0] divisor,
	output logic           busy,
	output logic [DSW-1:0] rem
);

	localparam int CNTW = $clog2(DVW + 1);

	logic [DVW-1:0]  quo_q;
	logic [DSW-1:0]  rem_q;
	logic [DSW-1:0]  div_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic [DSW:0]    trial;
	logic [DSW:0]    diff;
	logic            ge;

	// One quotient bit per cycle, restoring form.
	assign trial = {rem_q, quo_q[DVW-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNTW'(1);
			if (cnt_q == CNTW'(DVW - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVW-2:0], ge};
			rem_q <= ge ? diff[DSW-1:0] : trial[DSW-1:0];
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

>>> rtl/dsh_dp.sv
module dsh_dp #(
	parameter int MAX_LEVELS  = 7,
	parameter int HEIGHT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dsh_pkg::dsh_cmd_t                   cmd,
	output dsh_pkg::dsh_sts_t                   sts,
	input  logic [$clog2(MAX_LEVELS+1)-1:0]     gen_n,
	input  logic [$clog2(MAX_LEVELS+1)-1:0]     level,
	input  logic [2:0]                          phase,
	input  logic [MAX_LEVELS-1:0][1:0]          stack,
	input  logic                                corner,
	input  logic [1:0]                          corner_idx,
	input  logic [30:0]                         random_word,
	output logic                                m_valid,
	input  logic                                m_ready,
	output logic [31:0]                         m_data,
	output logic                                m_last
);

	localparam int LW   = $clog2(MAX_LEVELS + 1);
	localparam int CW   = MAX_LEVELS + 1;
	localparam int SIDE = (1 << MAX_LEVELS) + 1;
	localparam int AW   = $clog2(SIDE * SIDE);
	localparam int SUMW = HEIGHT_BITS + 2;
	localparam int DVW  = 31;
	localparam int RK   = SUMW + 1;
	localparam int PW   = SUMW + RK;
	localparam logic [RK-1:0] RECIP3 = RK'(((64'd1 << RK) + 64'd2) / 64'd3);
	localparam int TW   = ((HEIGHT_BITS > MAX_LEVELS + 2) ? HEIGHT_BITS : MAX_LEVELS + 2) + 3;
	localparam logic signed [TW-1:0] H_MAX = TW'((64'sd1 <<< (HEIGHT_BITS - 1)) - 64'sd1);
	localparam logic signed [TW-1:0] H_MIN = -H_MAX - TW'(1);

	function automatic logic [CW-1:0] wrap_dn(input logic [CW-1:0] a, input logic [CW-1:0] b,
		input logic [CW-1:0] lim);
		if (a < b) begin
			return lim;
		end
		return a - b;
	endfunction

	function automatic logic [CW-1:0] wrap_up(input logic [CW-1:0] a, input logic [CW-1:0] b,
		input logic [CW-1:0] lim);
		logic [CW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s > {1'b0, lim}) begin
			return '0;
		end
		return s[CW-1:0];
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
		return (AW'(r) << MAX_LEVELS) + AW'(r) + AW'(c);
	endfunction

	logic [CW-1:0] last, hs, x0, y0, x1, y1, mx, my;
	logic [CW-1:0] nb_r, nb_c, tg_r, tg_c;
	logic [CW-1:0] clr_r_q, clr_c_q;
	logic [30:0]   word_q;
	logic          rd_pend_s1;
	logic signed [SUMW-1:0] sum_q;
	logic [2:0]    cnt_q;
	logic [SUMW-1:0] mag, mean_mag;
	logic [PW-1:0] prod3;
	logic signed [TW-1:0] mean_s, rnd_s, hs_s, val, total;
	logic [HEIGHT_BITS-1:0] h_sat;
	logic [AW-1:0] ram_addr;
	logic          ram_we;
	logic [HEIGHT_BITS-1:0] ram_wdata, ram_rdata;
	logic [CW-1:0]  div_rem;
	logic           div_busy;
	logic [31:0]    h_ext;
	logic [15:0]    row_ext, col_ext;
	logic [7:0]     out_row_q, out_col_q;
	logic [15:0]    out_h_q;
	logic           out_last_q, out_valid_q;

	// Square geometry from the quadrant path.
	assign last = CW'(1) << gen_n;
	assign hs   = CW'(1) << (gen_n - level - LW'(1));

	always_comb begin
		x0 = '0;
		y0 = '0;
		for (int d = 1; d <= MAX_LEVELS; d++) begin
			if (LW'(d) <= level) begin
				x0 = x0 | (CW'(stack[d-1][0]) << (gen_n - LW'(d)));
				y0 = y0 | (CW'(stack[d-1][1]) << (gen_n - LW'(d)));
			end
		end
	end

	assign x1 = x0 + (hs << 1);
	assign y1 = y0 + (hs << 1);
	assign mx = x0 + hs;
	assign my = y0 + hs;

	always_comb begin
		nb_r = y0;
		nb_c = x0;
		case (phase)
			dsh_pkg::PH_CENTER: begin
				case (cmd.rd_sel)
					2'd0: begin nb_r = y0; nb_c = x0; end
					2'd1: begin nb_r = y0; nb_c = x1; end
					2'd2: begin nb_r = y1; nb_c = x0; end
					default: begin nb_r = y1; nb_c = x1; end
				endcase
			end
			dsh_pkg::PH_LEFT: begin
				case (cmd.rd_sel)
					2'd0: begin nb_r = y0; nb_c = x0; end
					2'd1: begin nb_r = y1; nb_c = x0; end
					2'd2: begin nb_r = my; nb_c = wrap_dn(x0, hs, last); end
					default: begin nb_r = my; nb_c = wrap_up(x0, hs, last); end
				endcase
			end
			dsh_pkg::PH_TOP: begin
				case (cmd.rd_sel)
					2'd0: begin nb_r = y0; nb_c = x0; end
					2'd1: begin nb_r = y0; nb_c = x1; end
					2'd2: begin nb_r = wrap_dn(y0, hs, last); nb_c = mx; end
					default: begin nb_r = wrap_up(y0, hs, last); nb_c = mx; end
				endcase
			end
			dsh_pkg::PH_RIGHT: begin
				case (cmd.rd_sel)
					2'd0: begin nb_r = y0; nb_c = x1; end
					2'd1: begin nb_r = y1; nb_c = x1; end
					2'd2: begin nb_r = my; nb_c = wrap_dn(x1, hs, last); end
					default: begin nb_r = my; nb_c = wrap_up(x1, hs, last); end
				endcase
			end
			default: begin
				case (cmd.rd_sel)
					2'd0: begin nb_r = y1; nb_c = x0; end
					2'd1: begin nb_r = y1; nb_c = x1; end
					2'd2: begin nb_r = wrap_dn(y1, hs, last); nb_c = mx; end
					default: begin nb_r = wrap_up(y1, hs, last); nb_c = mx; end
				endcase
			end
		endcase
	end

	always_comb begin
		tg_r = my;
		tg_c = mx;
		if (corner) begin
			tg_r = corner_idx[1] ? last : '0;
			tg_c = (corner_idx == 2'd1 || corner_idx == 2'd2) ? last : '0;
		end else begin
			case (phase)
				dsh_pkg::PH_CENTER: begin tg_r = my; tg_c = mx; end
				dsh_pkg::PH_LEFT:   begin tg_r = my; tg_c = x0; end
				dsh_pkg::PH_TOP:    begin tg_r = y0; tg_c = mx; end
				dsh_pkg::PH_RIGHT:  begin tg_r = my; tg_c = x1; end
				default:            begin tg_r = y1; tg_c = mx; end
			endcase
		end
	end

	// Clearing sweep over the grid of the new generation.
	always_ff @(posedge clk) begin
		if (cmd.clr_init) begin
			clr_r_q <= '0;
			clr_c_q <= '0;
		end else if (cmd.clr_step) begin
			if (clr_c_q == last) begin
				clr_c_q <= '0;
				clr_r_q <= clr_r_q + CW'(1);
			end else begin
				clr_c_q <= clr_c_q + CW'(1);
			end
		end
	end

	always_comb begin
		if (cmd.clr_step) begin
			ram_addr = addr_of(clr_r_q, clr_c_q);
		end else if (cmd.rd_issue) begin
			ram_addr = addr_of(nb_r, nb_c);
		end else begin
			ram_addr = addr_of(tg_r, tg_c);
		end
	end

	assign ram_we    = cmd.clr_step | cmd.wr;
	assign ram_wdata = cmd.clr_step ? '0 : h_sat;

	dsh_ram #(
		.WIDTH(HEIGHT_BITS),
		.DEPTH(SIDE * SIDE)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Sum and count of non-zero neighbours.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= cmd.rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_word) begin
			word_q <= random_word;
		end
		if (cmd.acc_init) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (rd_pend_s1 && ram_rdata != '0) begin
			sum_q <= sum_q + SUMW'($signed(ram_rdata));
			cnt_q <= cnt_q + 3'd1;
		end
	end

	assign mag = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);

	// Corner heights are the word modulo the side length.
	dsh_div #(
		.DVW(DVW),
		.DSW(CW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(word_q),
		.divisor (last + CW'(1)),
		.busy    (div_busy),
		.rem     (div_rem)
	);

	// A third by reciprocal multiplication; exact for every sum of three heights.
	assign prod3 = PW'(mag) * PW'(RECIP3);

	always_comb begin
		case (cnt_q)
			3'd1:    mean_mag = mag;
			3'd2:    mean_mag = mag >> 1;
			3'd3:    mean_mag = prod3[PW-1:RK];
			3'd4:    mean_mag = mag >> 2;
			default: mean_mag = '0;
		endcase
	end

	assign mean_s = sum_q[SUMW-1] ? -TW'(mean_mag) : TW'(mean_mag);
	assign rnd_s  = TW'(word_q[CW-1:0] & ((hs << 1) - CW'(1)));
	assign hs_s   = TW'(hs);
	assign total  = mean_s + rnd_s - hs_s;
	assign val    = corner ? TW'(div_rem) : total;

	always_comb begin
		if (val > H_MAX) begin
			h_sat = H_MAX[HEIGHT_BITS-1:0];
		end else if (val < H_MIN) begin
			h_sat = H_MIN[HEIGHT_BITS-1:0];
		end else begin
			h_sat = val[HEIGHT_BITS-1:0];
		end
	end

	assign h_ext   = 32'($signed(h_sat));
	assign row_ext = 16'(tg_r);
	assign col_ext = 16'(tg_c);

	// Result register parts the stream sides.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.wr) begin
			out_valid_q <= 1'b1;
		end else if (m_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			out_row_q  <= row_ext[7:0];
			out_col_q  <= col_ext[7:0];
			out_h_q    <= h_ext[15:0];
			out_last_q <= cmd.fin;
		end
	end

	assign m_valid = out_valid_q;
	assign m_data  = {out_h_q, out_col_q, out_row_q};
	assign m_last  = out_last_q;

	assign sts.clr_done = (clr_r_q == last) && (clr_c_q == last);
	assign sts.div_busy = div_busy;
	assign sts.out_full = out_valid_q && !m_ready;

endmodule

>>> rtl/dsh_ctrl.sv
module dsh_ctrl #(
	parameter int MAX_LEVELS = 7
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [2:0]                      cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	output dsh_pkg::dsh_cmd_t               cmd,
	input  dsh_pkg::dsh_sts_t               sts,
	output logic [$clog2(MAX_LEVELS+1)-1:0] gen_n,
	output logic [$clog2(MAX_LEVELS+1)-1:0] level,
	output logic [2:0]                      phase,
	output logic [MAX_LEVELS-1:0][1:0]      stack,
	output logic                            corner,
	output logic [1:0]                      corner_idx
);

	localparam int LW = $clog2(MAX_LEVELS + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CLR  = 3'd1;
	localparam logic [2:0] S_CDIV = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_ACC  = 3'd4;
	localparam logic [2:0] S_MEAN = 3'd5;
	localparam logic [2:0] S_DIV  = 3'd6;
	localparam logic [2:0] S_WR   = 3'd7;

	logic [2:0]    state_q;
	logic [2:0]    levels_q;
	logic [LW-1:0] n_q, n_next, level_q, pop_lvl;
	logic [2:0]    phase_q, corner_cnt_q;
	logic [MAX_LEVELS-1:0][1:0] stack_q;
	logic [1:0]    rd_k_q;
	logic          accept, descend, fin;

	assign accept = in_valid && in_ready;
	assign in_ready = state_q == S_IDLE;
	assign corner = corner_cnt_q < dsh_pkg::CORNER_COUNT;

	always_comb begin
		if (levels_q == 3'd0) begin
			n_next = LW'(1);
		end else if (32'(levels_q) > MAX_LEVELS) begin
			n_next = LW'(MAX_LEVELS);
		end else begin
			n_next = LW'(levels_q);
		end
	end

	// Deepest enclosing square that still has a quadrant left.
	always_comb begin
		pop_lvl = '0;
		for (int d = 1; d <= MAX_LEVELS; d++) begin
			if (LW'(d) <= level_q && stack_q[d-1] != dsh_pkg::QUAD_LAST) begin
				pop_lvl = LW'(d);
			end
		end
	end

	assign descend = ({1'b0, level_q} + (LW+1)'(1)) < {1'b0, n_q};
	assign fin = !corner && phase_q == dsh_pkg::PH_BOTTOM && !descend && pop_lvl == '0;

	always_comb begin
		cmd = '0;
		cmd.load_word = accept;
		cmd.acc_init  = accept;
		cmd.clr_init  = accept && corner_cnt_q == '0;
		cmd.rd_sel    = rd_k_q;
		case (state_q)
			S_CLR:  cmd.clr_step = 1'b1;
			S_CDIV: cmd.div_start = 1'b1;
			S_RD:   cmd.rd_issue = 1'b1;
			S_WR: begin
				cmd.wr  = !sts.out_full;
				cmd.fin = fin;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= 3'd7;
		end else if (cfg_we) begin
			levels_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			n_q          <= LW'(MAX_LEVELS);
			level_q      <= '0;
			phase_q      <= dsh_pkg::PH_CENTER;
			corner_cnt_q <= '0;
			stack_q      <= '0;
			rd_k_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_k_q <= '0;
						if (corner_cnt_q == '0) begin
							n_q     <= n_next;
							state_q <= S_CLR;
						end else if (corner) begin
							state_q <= S_CDIV;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_CLR: begin
					if (sts.clr_done) begin
						state_q <= S_CDIV;
					end
				end
				S_CDIV: state_q <= S_DIV;
				S_RD: begin
					rd_k_q <= rd_k_q + 2'd1;
					if (rd_k_q == dsh_pkg::NB_LAST) begin
						state_q <= S_ACC;
					end
				end
				S_ACC:  state_q <= S_MEAN;
				S_MEAN: state_q <= S_WR;
				S_DIV: begin
					if (!sts.div_busy) begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					if (!sts.out_full) begin
						state_q <= S_IDLE;
						if (corner) begin
							corner_cnt_q <= corner_cnt_q + 3'd1;
							if (corner_cnt_q + 3'd1 == dsh_pkg::CORNER_COUNT) begin
								level_q <= '0;
								phase_q <= dsh_pkg::PH_CENTER;
								stack_q <= '0;
							end
						end else if (phase_q != dsh_pkg::PH_BOTTOM) begin
							phase_q <= phase_q + 3'd1;
						end else begin
							phase_q <= dsh_pkg::PH_CENTER;
							if (descend) begin
								level_q <= level_q + LW'(1);
								for (int d = 0; d < MAX_LEVELS; d++) begin
									if (LW'(d) == level_q) begin
										stack_q[d] <= '0;
									end
								end
							end else begin
								level_q <= pop_lvl;
								if (pop_lvl == '0) begin
									corner_cnt_q <= '0;
								end
								for (int d = 0; d < MAX_LEVELS; d++) begin
									if (LW'(d + 1) == pop_lvl) begin
										stack_q[d] <= stack_q[d] + 2'd1;
									end
								end
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign gen_n      = n_q;
	assign level      = level_q;
	assign phase      = phase_q;
	assign stack      = stack_q;
	assign corner_idx = corner_cnt_q[1:0];

endmodule

>>> rtl/diamond_square_heightmap_top.sv
// Ordinary point: after its word is accepted, four neighbour reads, the mean and the write
//   follow, and the next word is taken once the result word is in the result register.
// Corner point: the result word is the word modulo the side length, from the restoring divider.
// First word of a generation first clears the (2^n+1)^2 grid, one cell a cycle.
// Reset (arst_n low, asynchronous) idles the controller and sets levels to 7.
module diamond_square_heightmap_top #(
	parameter int MAX_LEVELS  = 7,
	parameter int HEIGHT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,       // levels_in_use
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,    // [30:0] random_word, [31] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,    // [7:0] cell_row, [15:8] cell_col, [31:16] cell_height
	output logic        m_axis_tlast     // final_point
);

	// The controller walks the squares depth first and sequences the
	// single-port height memory: four neighbour reads per ordinary point, then one write.
	// The datapath holds geometry, the height memory, the corner divider
	// and the result register. A new word is taken while the previous
	// result word still waits on the output side.

	localparam int LW = $clog2(MAX_LEVELS + 1);

	dsh_pkg::dsh_cmd_t cmd;
	dsh_pkg::dsh_sts_t sts;
	logic [LW-1:0] gen_n, level;
	logic [2:0]    phase;
	logic [MAX_LEVELS-1:0][1:0] stack;
	logic          corner;
	logic [1:0]    corner_idx;

	dsh_ctrl #(
		.MAX_LEVELS(MAX_LEVELS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.cmd       (cmd),
		.sts       (sts),
		.gen_n     (gen_n),
		.level     (level),
		.phase     (phase),
		.stack     (stack),
		.corner    (corner),
		.corner_idx(corner_idx)
	);

	dsh_dp #(
		.MAX_LEVELS (MAX_LEVELS),
		.HEIGHT_BITS(HEIGHT_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.gen_n      (gen_n),
		.level      (level),
		.phase      (phase),
		.stack      (stack),
		.corner     (corner),
		.corner_idx (corner_idx),
		.random_word(s_axis_tdata[30:0]),
		.m_valid    (m_axis_tvalid),
		.m_ready    (m_axis_tready),
		.m_data     (m_axis_tdata),
		.m_last     (m_axis_tlast)
	);

endmodule
